// File: rtl/lzw_pkg.sv
// shared constants for the lzw code stream decoder
package lzw_pkg;

  localparam int CODE_BITS   = 9;
  localparam int BYTES_PER_RESULT = 8;
  localparam int TOP_CODE    = (1 << CODE_BITS) - 1;
  localparam int TABLE_DEPTH = TOP_CODE - 256;
  localparam int WALK_LIMIT  = TABLE_DEPTH + 1;
  localparam int STACK_DEPTH = TABLE_DEPTH + 3;
  localparam int TAW         = $clog2(TABLE_DEPTH);
  localparam int SAW         = $clog2(STACK_DEPTH);
  localparam int NW          = $clog2(STACK_DEPTH + 1);
  localparam int STW         = $clog2(WALK_LIMIT + 1);
  localparam int DICT_W      = CODE_BITS + 8;

  localparam logic [1:0] STATUS_RUN  = 2'd0;
  localparam logic [1:0] STATUS_END  = 2'd1;
  localparam logic [1:0] STATUS_FAIL = 2'd2;

endpackage

// File: rtl/lzw_ifs.sv
// valid/ready channel interfaces for codes, results and configuration
interface lzw_in_if;
  import lzw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code_word;
  logic                 final_code;
  modport source (output valid, code_word, final_code, input ready);
  modport sink (input valid, code_word, final_code, output ready);
endinterface

interface lzw_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        last_of_run;
  logic [1:0]  status;
  logic [16:0] total_bytes;
  modport source (output valid, out_bytes, byte_count, last_of_run, status, total_bytes,
                  input ready);
  modport sink (input valid, out_bytes, byte_count, last_of_run, status, total_bytes,
                output ready);
endinterface

interface lzw_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_capacity;
  modport source (output valid, out_capacity, input ready);
  modport sink (input valid, out_capacity, output ready);
endinterface

// File: rtl/lzw_ram.sv
// generic simple dual port ram with registered read
module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/lzw_code_stream_decoder_unit.sv
// lzw code stream decoder top level
// Takes one code per transfer and returns its string as result items of up to eight bytes,
// first byte lowest. The walk reads the dictionary ram once per dictionary entry on the
// code's chain, and the string is read back from the reversal stack ram one byte per cycle
// while a full result item is not held up by the output. First-of-frame and end codes skip
// the walk. The next code is taken while the last result still waits on the output.
// The dictionary has one valid flop per entry, so there is no clearing pass after reset.
module lzw_code_stream_decoder_unit
  import lzw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lzw_in_if.sink    in_ch,
  lzw_out_if.source out_ch,
  lzw_cfg_if.sink   cfg
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CODE_BITS-1:0] TOP   = CODE_BITS'(TOP_CODE);
  localparam logic [CODE_BITS-1:0] FIRST = CODE_BITS'(256);

  logic [2:0]             state;
  logic [15:0]            capacity;
  logic [CODE_BITS-1:0]   prev_code;
  logic [7:0]             prev_first;
  logic [CODE_BITS-1:0]   next_free;
  logic                   awaiting;
  logic [16:0]            emitted;
  logic [(1<<TAW)-1:0]    dvalid;

  logic [CODE_BITS-1:0]   code_r;
  logic                   fin_r;
  logic [CODE_BITS-1:0]   w;
  logic [STW-1:0]         steps;
  logic [NW-1:0]          n;
  logic                   pend;
  logic                   rd_ok;
  logic [7:0]             first;
  logic [63:0]            acc;
  logic [3:0]             cnt;
  logic [1:0]             status_r;
  logic                   upd;

  logic                   ov_valid;
  logic [63:0]            ov_bytes;
  logic [3:0]             ov_count;
  logic                   ov_last;
  logic [1:0]             ov_status;
  logic [16:0]            ov_total;

  logic                   dict_we;
  logic [TAW-1:0]         dict_waddr;
  logic [TAW-1:0]         dict_raddr;
  logic [DICT_W-1:0]      dict_rdata;
  logic                   stk_we;
  logic [SAW-1:0]         stk_waddr;
  logic [7:0]             stk_wdata;
  logic [SAW-1:0]         stk_raddr;
  logic [7:0]             stk_rdata;

  logic                   in_xfer;
  logic                   out_free;
  logic [CODE_BITS-1:0]   pre_val;
  logic [7:0]             suf_val;
  logic [CODE_BITS-1:0]   cur_w;
  logic [63:0]            acc_abs;
  logic [3:0]             cnt_abs;
  logic                   full;
  logic                   ovf;

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign cfg.ready   = 1'b1;
  assign out_free    = !ov_valid || out_ch.ready;

  assign out_ch.valid       = ov_valid;
  assign out_ch.out_bytes   = ov_bytes;
  assign out_ch.byte_count  = ov_count;
  assign out_ch.last_of_run = ov_last;
  assign out_ch.status      = ov_status;
  assign out_ch.total_bytes = ov_total;

  always_comb begin
    pre_val = rd_ok ? dict_rdata[DICT_W-1:8] : '0;
    suf_val = rd_ok ? dict_rdata[7:0] : '0;
    cur_w   = pend ? pre_val : w;
    acc_abs = pend ? (acc | (64'(stk_rdata) << {cnt[2:0], 3'b000})) : acc;
    cnt_abs = cnt + 4'(pend);
    full    = (cnt_abs == 4'(BYTES_PER_RESULT)) && (n != '0);
    ovf     = (emitted - 17'd1) >= {1'b0, capacity};
  end

  // stack write: previous first byte, chain suffixes, then the root byte
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = n[SAW-1:0];
    stk_wdata = suf_val;
    unique case (state)
      S_IDLE: begin
        stk_we    = in_xfer && !awaiting && (in_ch.code_word != TOP) &&
                    (in_ch.code_word >= next_free);
        stk_waddr = '0;
        stk_wdata = prev_first;
      end
      S_WALK: stk_we = pend;
      S_ROOT: begin
        stk_we    = 1'b1;
        stk_wdata = w[7:0];
      end
      default: stk_we = 1'b0;
    endcase
  end

  assign stk_raddr  = SAW'(n - NW'(1));
  assign dict_raddr = TAW'(cur_w - FIRST);
  assign dict_waddr = TAW'(next_free - FIRST);
  assign dict_we    = (state == S_DONE) && out_free && upd && (next_free < TOP);

  lzw_ram #(.WIDTH(DICT_W), .DEPTH(TABLE_DEPTH)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata ({prev_code, first}),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  lzw_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      capacity   <= 16'hFFFF;
      prev_code  <= '0;
      prev_first <= '0;
      next_free  <= FIRST;
      awaiting   <= 1'b1;
      emitted    <= '0;
      dvalid     <= '0;
      pend       <= 1'b0;
      ov_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        capacity <= cfg.out_capacity;
      end
      if (ov_valid && out_ch.ready) begin
        ov_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            code_r <= in_ch.code_word;
            fin_r  <= in_ch.final_code;
            upd    <= 1'b0;
            pend   <= 1'b0;
            steps  <= '0;
            if (awaiting) begin
              awaiting   <= 1'b0;
              prev_code  <= in_ch.code_word;
              prev_first <= in_ch.code_word[7:0];
              emitted    <= 17'd1;
              acc        <= 64'(in_ch.code_word[7:0]);
              cnt        <= 4'd1;
              status_r   <= in_ch.final_code ? STATUS_FAIL : STATUS_RUN;
              state      <= S_DONE;
            end else if (in_ch.code_word == TOP) begin
              acc      <= '0;
              cnt      <= '0;
              status_r <= STATUS_END;
              state    <= S_DONE;
            end else if (in_ch.code_word >= next_free) begin
              n     <= NW'(1);
              w     <= prev_code;
              state <= S_WALK;
            end else begin
              n     <= '0;
              w     <= in_ch.code_word;
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (pend) begin
            n <= n + NW'(1);
          end
          w <= cur_w;
          if (cur_w > CODE_BITS'(255)) begin
            if (steps < STW'(WALK_LIMIT)) begin
              steps <= steps + STW'(1);
              pend  <= 1'b1;
              rd_ok <= dvalid[dict_raddr];
            end else begin
              // chain guard tripped
              pend     <= 1'b0;
              acc      <= '0;
              cnt      <= '0;
              status_r <= STATUS_FAIL;
              state    <= S_DONE;
            end
          end else begin
            pend  <= 1'b0;
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          n     <= n + NW'(1);
          first <= w[7:0];
          acc   <= '0;
          cnt   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          pend <= 1'b0;
          acc  <= acc_abs;
          cnt  <= cnt_abs;
          if (full) begin
            if (out_free) begin
              ov_valid  <= 1'b1;
              ov_bytes  <= acc_abs;
              ov_count  <= cnt_abs;
              ov_last   <= 1'b0;
              ov_status <= STATUS_RUN;
              ov_total  <= emitted;
              acc       <= '0;
              cnt       <= '0;
            end
          end else if (n != '0) begin
            if (ovf) begin
              status_r <= STATUS_FAIL;
              upd      <= 1'b0;
              state    <= S_DONE;
            end else begin
              n       <= n - NW'(1);
              emitted <= emitted + 17'd1;
              pend    <= 1'b1;
            end
          end else begin
            status_r <= fin_r ? STATUS_FAIL : STATUS_RUN;
            upd      <= 1'b1;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            ov_valid  <= 1'b1;
            ov_bytes  <= acc;
            ov_count  <= cnt;
            ov_last   <= 1'b1;
            ov_status <= status_r;
            ov_total  <= emitted;
            if (upd) begin
              if (next_free < TOP) begin
                dvalid[dict_waddr] <= 1'b1;
                next_free          <= next_free + CODE_BITS'(1);
              end
              prev_code  <= code_r;
              prev_first <= first;
            end
            if (status_r != STATUS_RUN) begin
              awaiting  <= 1'b1;
              next_free <= FIRST;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_free_code_range: assert property (@(posedge clk) disable iff (rst)
    (next_free >= FIRST) && (next_free <= TOP))
    else $error("next free code out of range");

  a_inner_item_full: assert property (@(posedge clk) disable iff (rst)
    (ov_valid && !ov_last) |-> ((ov_count == 4'(BYTES_PER_RESULT)) &&
                                (ov_status == STATUS_RUN)))
    else $error("inner result item not full or has status");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (steps <= STW'(WALK_LIMIT)))
    else $error("walk ran past the chain guard");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (n <= NW'(STACK_DEPTH)))
    else $error("stack pointer past depth");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (in_xfer) |=> (state != S_IDLE))
    else $error("transfer taken without leaving idle");

endmodule

// File: sim/tb_lzw_code_stream_decoder_unit.sv
// testbench for the lzw code stream decoder: directed table, random frames, scoreboard check
`timescale 1ns / 100ps

module tb_lzw_code_stream_decoder_unit
  import lzw_pkg::*;
;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_run;
    logic [1:0]  status;
    logic [16:0] total_bytes;
  } dec_result_t;

  typedef struct {
    logic [CODE_BITS-1:0] code;
    logic                 fin;
    logic                 has_exp;
    logic [63:0]          exp_bytes;
    logic [1:0]           exp_status;
  } code_row_t;

  logic clk;
  logic rst;
  lzw_in_if  in_ch();
  lzw_out_if out_ch();
  lzw_cfg_if cfg();

  lzw_code_stream_decoder_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [CODE_BITS-1:0] dict_prefix [TABLE_DEPTH];
  logic [7:0]           dict_suffix [TABLE_DEPTH];
  logic [CODE_BITS-1:0] last_code;
  logic [7:0]           last_first;
  int unsigned          free_code;
  bit                   want_first;
  int unsigned          byte_total;
  int unsigned          capacity;

  dec_result_t expected_q[$];
  int          fail_count;
  int unsigned cycle_count;
  bit          idle_enable;
  bit          long_hold;
  int          hold_cycles;
  code_row_t   direct_rows[$];

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  function automatic void close_frame();
    want_first = 1'b1;
    free_code  = 256;
  endfunction

  function automatic void push_result(logic [63:0] b, int unsigned cnt, bit last,
                                      logic [1:0] st);
    dec_result_t r;
    r.out_bytes   = b;
    r.byte_count  = cnt[3:0];
    r.last_of_run = last;
    r.status      = st;
    r.total_bytes = byte_total[16:0];
    expected_q.push_back(r);
  endfunction

  function automatic void decode_code(logic [CODE_BITS-1:0] code, bit fin);
    logic [7:0]  stack[$];
    int unsigned w, steps, first, cnt;
    logic [63:0] acc;
    bit          ovf;
    logic [1:0]  st;
    acc = '0;
    cnt = 0;
    steps = 0;
    ovf = 1'b0;
    if (want_first) begin
      want_first = 1'b0;
      last_code  = code;
      last_first = code[7:0];
      byte_total = 1;
      st = fin ? STATUS_FAIL : STATUS_RUN;
      if (fin) close_frame();
      push_result({56'd0, code[7:0]}, 1, 1'b1, st);
      return;
    end
    if (code == TOP_CODE) begin
      close_frame();
      push_result('0, 0, 1'b1, STATUS_END);
      return;
    end
    if (code >= free_code) begin
      stack.push_back(last_first);
      w = 32'(last_code);
    end else begin
      w = 32'(code);
    end
    while (w > 255 && steps < WALK_LIMIT) begin
      if (w - 256 < TABLE_DEPTH) begin
        if (stack.size() < STACK_DEPTH) stack.push_back(dict_suffix[w - 256]);
        w = 32'(dict_prefix[w - 256]);
      end else begin
        // top code has no entry: reads as zero
        if (stack.size() < STACK_DEPTH) stack.push_back(8'd0);
        w = 0;
      end
      steps++;
    end
    if (w > 255) begin
      close_frame();
      push_result('0, 0, 1'b1, STATUS_FAIL);
      return;
    end
    if (stack.size() < STACK_DEPTH) stack.push_back(w[7:0]);
    first = w;
    while (stack.size() > 0) begin
      if (byte_total - 1 >= capacity) begin
        ovf = 1'b1;
        break;
      end
      acc |= 64'(stack.pop_back()) << (8 * cnt);
      cnt++;
      byte_total++;
      if (cnt == BYTES_PER_RESULT && stack.size() > 0) begin
        push_result(acc, cnt, 1'b0, STATUS_RUN);
        acc = '0;
        cnt = 0;
      end
    end
    if (!ovf) begin
      if (free_code < TOP_CODE) begin
        dict_prefix[free_code - 256] = last_code;
        dict_suffix[free_code - 256] = first[7:0];
        free_code++;
      end
      last_code  = code;
      last_first = first[7:0];
    end
    st = (ovf || fin) ? STATUS_FAIL : STATUS_RUN;
    if (st == STATUS_FAIL) close_frame();
    push_result(acc, cnt, 1'b1, st);
  endfunction

  // sender idle: random idle bursts before some codes; valid stays up between back to back codes
  task automatic send_code(input int code, input int fin);
    int gap;
    logic [CODE_BITS-1:0] cw;
    bit fb;
    cw = code[CODE_BITS-1:0];
    fb = fin[0];
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = int'($urandom_range(1, 13));
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.code_word  <= cw;
    in_ch.final_code <= fb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_code(cw, fb);
  endtask

  task automatic drain_then_idle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] value);
    cfg.valid        <= 1'b1;
    cfg.out_capacity <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    capacity = 32'(value);
    @(posedge clk);
  endtask

  function automatic void add_row(int code, int fin, int has, logic [63:0] b,
                                  logic [1:0] st);
    code_row_t r;
    r.code = code[CODE_BITS-1:0];
    r.fin = fin[0];
    r.has_exp = has[0];
    r.exp_bytes = b;
    r.exp_status = st;
    direct_rows.push_back(r);
  endfunction

  // random frame: mostly valid codes, sometimes noise, cSc cases and early ends
  task automatic random_frame(int len);
    int k, c, roll, fin;
    send_code(int'($urandom_range(0, 255)), 0);
    for (k = 0; k < len; k++) begin
      roll = int'($urandom_range(0, 99));
      if (roll < 55) c = int'($urandom_range(0, 255));
      else if (roll < 80 && free_code > 256) c = int'($urandom_range(256, free_code - 1));
      else if (roll < 92) c = int'(free_code);
      else c = int'($urandom_range(0, TOP_CODE - 1));
      fin = ($urandom_range(0, 40) == 0) ? 1 : 0;
      send_code(c, fin);
      if (fin != 0) return;
    end
    if ($urandom_range(0, 5) != 0) send_code(TOP_CODE, int'($urandom_range(0, 1)));
  endtask

  // result checker
  always @(posedge clk) begin
    dec_result_t got, exp;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_bytes, out_ch.byte_count, out_ch.last_of_run, out_ch.status,
              out_ch.total_bytes};
      if (expected_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        exp = expected_q.pop_front();
        if (got.out_bytes !== exp.out_bytes)
          report_mismatch($sformatf("out_bytes %h exp %h", got.out_bytes, exp.out_bytes));
        if (got.byte_count !== exp.byte_count)
          report_mismatch($sformatf("byte_count %0d exp %0d", got.byte_count,
                                    exp.byte_count));
        if (got.last_of_run !== exp.last_of_run)
          report_mismatch($sformatf("last_of_run %b exp %b", got.last_of_run,
                                    exp.last_of_run));
        if (got.status !== exp.status)
          report_mismatch($sformatf("status %0d exp %0d", got.status, exp.status));
        if (got.total_bytes !== exp.total_bytes)
          report_mismatch($sformatf("total_bytes %0d exp %0d", got.total_bytes,
                                    exp.total_bytes));
      end
    end
  end

  // receiver stall process
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        gap = int'($urandom_range(1, 13));
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int i, j, k;
    int unsigned caps[4];
    code_row_t r;
    logic [63:0] got_bytes;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.code_word = '0;
    in_ch.final_code = 1'b0;
    cfg.valid = 1'b0;
    cfg.out_capacity = '0;
    fail_count = 0;
    idle_enable = 1'b1;
    long_hold = 1'b0;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      dict_prefix[i] = '0;
      dict_suffix[i] = '0;
    end
    last_code = '0;
    last_first = '0;
    free_code = 256;
    want_first = 1'b1;
    byte_total = 0;
    capacity = 65535;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: first byte, top code taken as data, end code, chains, cSc case
    add_row('h41, 0, 1, 64'h41, STATUS_RUN);
    add_row('h42, 0, 0, 64'h0, STATUS_RUN);
    add_row(256, 0, 0, 64'h0, STATUS_RUN);
    add_row(258, 0, 0, 64'h0, STATUS_RUN);
    add_row(259, 0, 0, 64'h0, STATUS_RUN);
    add_row(260, 0, 0, 64'h0, STATUS_RUN);
    add_row(261, 0, 0, 64'h0, STATUS_RUN);
    add_row(263, 0, 0, 64'h0, STATUS_RUN);
    add_row(TOP_CODE, 0, 1, 64'h0, STATUS_END);
    add_row(TOP_CODE, 0, 1, 64'hff, STATUS_RUN);
    add_row(256, 0, 0, 64'h0, STATUS_RUN);
    add_row(0, 1, 0, 64'h0, STATUS_RUN);
    add_row('hff, 1, 1, 64'hff, STATUS_FAIL);
    add_row(0, 0, 1, 64'h0, STATUS_RUN);
    add_row(TOP_CODE, 1, 1, 64'h0, STATUS_END);
    foreach (direct_rows[i]) begin
      r = direct_rows[i];
      send_code(int'(r.code), int'(r.fin));
      if (r.has_exp) begin
        // the typed result is the newest expectation the predictor queued
        got_bytes = expected_q[$].out_bytes;
        if (got_bytes !== r.exp_bytes || expected_q[$].status !== r.exp_status)
          report_mismatch($sformatf("row %0d predictor disagrees with table", i));
      end
    end
    drain_then_idle();

    // overflow at capacity 0 and small capacity, then self-referencing chain
    write_capacity(16'd0);
    send_code('h10, 0);
    send_code('h11, 0);
    send_code('h20, 0);
    send_code(257, 0);
    drain_then_idle();
    write_capacity(16'd5);
    send_code('h30, 0);
    send_code(256, 0);
    send_code(257, 0);
    send_code(258, 0);
    drain_then_idle();

    // long output hold while codes keep arriving
    write_capacity(16'd65535);
    long_hold = 1'b1;
    send_code('h01, 0);
    for (i = 0; i < 30; i++) send_code(256 + i, 0);
    send_code(TOP_CODE, 0);
    drain_then_idle();

    // random frames over several capacity settings, extremes included
    caps[0] = 65535;
    caps[1] = 0;
    caps[2] = $urandom_range(1, 40);
    caps[3] = 65535;
    for (k = 0; k < 4; k++) begin
      write_capacity(caps[k][15:0]);
      if (k == 3) idle_enable = 1'b0;
      for (j = 0; j < 6; j++) random_frame(int'($urandom_range(3, 20)));
      drain_then_idle();
    end
    // one long frame, long enough to fill the dictionary unless it ends early
    write_capacity(16'hffff);
    random_frame(270);
    drain_then_idle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
